// ----- rtl/cbst_pkg.sv -----
package cbst_pkg;

    // fixed field widths
    localparam int BYTE_W    = 8;
    localparam int KIND_W    = 2;
    localparam int MAJOR_W   = 3;
    localparam int ARG_W     = 64;
    localparam int NEST_W    = 4;
    localparam int ERR_W     = 3;
    localparam int STR_LIM_W = 17;
    localparam int ARR_LIM_W = 10;
    localparam int MAP_LIM_W = 7;
    localparam int CNT_W     = 10;
    localparam int EXT_W     = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = STR_LIM_W;

    // open-level counter covers the deepest allowed stack (counts up to 31 levels)
    localparam int OPEN_W          = 5;
    localparam int MAX_DEPTH_DEF   = 12;
    localparam int SHORT_ARG_MAX   = 23;
    localparam int EXT_ARG_MAX     = 27;

    // configuration register reset values
    localparam logic [STR_LIM_W-1:0] STR_LIM_RST = 17'd65536;
    localparam logic [ARR_LIM_W-1:0] ARR_LIM_RST = 10'd512;
    localparam logic [MAP_LIM_W-1:0] MAP_LIM_RST = 7'd64;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_STRING = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ARRAY  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_MAP    = 2'd2;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_HEADER  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ERROR   = 2'd2;

    // error codes
    localparam logic [ERR_W-1:0] ERR_NONE      = 3'd0;
    localparam logic [ERR_W-1:0] ERR_BAD_AI    = 3'd1;
    localparam logic [ERR_W-1:0] ERR_TOO_DEEP  = 3'd2;
    localparam logic [ERR_W-1:0] ERR_OVER_LIM  = 3'd3;
    localparam logic [ERR_W-1:0] ERR_TRUNCATED = 3'd4;

    // major types
    localparam logic [MAJOR_W-1:0] MT_BSTR  = 3'd2;
    localparam logic [MAJOR_W-1:0] MT_TSTR  = 3'd3;
    localparam logic [MAJOR_W-1:0] MT_ARRAY = 3'd4;
    localparam logic [MAJOR_W-1:0] MT_MAP   = 3'd5;
    localparam logic [MAJOR_W-1:0] MT_TAG   = 3'd6;

    // stack commands
    localparam logic [1:0] STK_NONE  = 2'd0;
    localparam logic [1:0] STK_PUSH  = 2'd1;
    localparam logic [1:0] STK_POP   = 2'd2;
    localparam logic [1:0] STK_CLEAR = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [MAJOR_W-1:0] major_type;
        logic [ARG_W-1:0]   argument;
        logic [NEST_W-1:0]  nesting;
        logic [BYTE_W-1:0]  payload_byte;
        logic               top_done;
        logic [ERR_W-1:0]   error_code;
    } t_result;

    typedef struct packed {
        logic [1:0]       op;
        logic [CNT_W-1:0] count;
    } t_stk_cmd;

    typedef struct packed {
        logic [OPEN_W-1:0] open;
        logic              close_all;
    } t_stk_stat;

    function automatic t_result f_fault(input logic [ERR_W-1:0] code);
        t_result r;
        r            = '0;
        r.kind       = KIND_ERROR;
        r.error_code = code;
        return r;
    endfunction

endpackage

// ----- rtl/cbst_in_reg.sv -----
module cbst_in_reg
    import cbst_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [BYTE_W-1:0] i_data_byte,
    input  logic              i_end_of_buffer,
    input  logic              i_take,
    output logic              o_valid,
    output logic [BYTE_W-1:0] o_data_byte,
    output logic              o_end_of_buffer
);

    logic              r_vld;
    logic [BYTE_W-1:0] r_byte;
    logic              r_eob;

    // slot frees up in the same cycle its byte is processed
    assign o_ready = !r_vld || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_byte <= i_data_byte;
            r_eob  <= i_end_of_buffer;
        end
    end

    assign o_valid         = r_vld;
    assign o_data_byte     = r_byte;
    assign o_end_of_buffer = r_eob;

endmodule

// ----- rtl/cbst_stack.sv -----
module cbst_stack
    import cbst_pkg::*;
#(
    parameter int MAX_DEPTH = MAX_DEPTH_DEF
)
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_stk_cmd  i_cmd,
    output t_stk_stat o_stat
);

    localparam int LEVELS = MAX_DEPTH + 1;
    localparam int IW     = $clog2(LEVELS);

    logic [CNT_W-1:0]  r_rem [LEVELS];
    logic              r_one [LEVELS];
    logic [OPEN_W-1:0] r_open;
    logic [OPEN_W-1:0] n_open;
    logic              found;
    logic [IW-1:0]     sel;

    // deepest open level that does not close when one more child finishes
    always_comb begin
        found = 1'b0;
        sel   = '0;
        for (int i = 0; i < LEVELS; i++) begin
            if ((OPEN_W'(i) < r_open) && !r_one[i]) begin
                found = 1'b1;
                sel   = IW'(i);
            end
        end
    end

    assign o_stat.open      = r_open;
    assign o_stat.close_all = !found;

    // open-level count
    always_comb begin
        n_open = r_open;
        case (i_cmd.op)
            STK_PUSH:  n_open = r_open + OPEN_W'(1);
            STK_POP:   n_open = found ? OPEN_W'(sel) + OPEN_W'(1) : '0;
            STK_CLEAR: n_open = '0;
            default:   n_open = r_open;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= '0;
        end else begin
            r_open <= n_open;
        end
    end

    // child counts, only read below the open count
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == STK_PUSH) begin
            r_rem[r_open[IW-1:0]] <= i_cmd.count;
            r_one[r_open[IW-1:0]] <= (i_cmd.count == CNT_W'(1));
        end else if (i_cmd.op == STK_POP && found) begin
            r_rem[sel] <= r_rem[sel] - CNT_W'(1);
            r_one[sel] <= (r_rem[sel] == CNT_W'(2));
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_open <= OPEN_W'(LEVELS))
    else $error("open level count beyond stack size");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.op == STK_PUSH |-> r_open <= OPEN_W'(MAX_DEPTH))
    else $error("push into a full stack");

endmodule

// ----- rtl/cbst_parser.sv -----
module cbst_parser
    import cbst_pkg::*;
#(
    parameter int MAX_DEPTH = MAX_DEPTH_DEF
)
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    input  logic                 i_in_valid,
    input  logic [BYTE_W-1:0]    i_data_byte,
    input  logic                 i_end_of_buffer,
    input  logic                 i_out_free,
    output logic                 o_take,
    output logic                 o_res_valid,
    output t_result              o_res
);

    localparam logic [1:0] PH_INIT    = 2'd0;
    localparam logic [1:0] PH_EXT     = 2'd1;
    localparam logic [1:0] PH_PAYLOAD = 2'd2;
    localparam logic [1:0] PH_IDLE    = 2'd3;

    logic [STR_LIM_W-1:0] r_max_str;
    logic [ARR_LIM_W-1:0] r_max_arr;
    logic [MAP_LIM_W-1:0] r_max_map;

    logic [1:0]           r_phase,    n_phase;
    logic [MAJOR_W-1:0]   r_major,    n_major;
    logic [EXT_W-1:0]     r_ext_left, n_ext_left;
    logic [ARG_W-1:0]     r_arg,      n_arg;
    logic [STR_LIM_W-1:0] r_pay_left, n_pay_left;

    t_stk_cmd             cmd;
    t_stk_stat            st;
    t_result              res;
    logic                 res_vld;
    logic                 hdr_go;
    logic [ARG_W-1:0]     hdr_arg;
    logic [MAJOR_W-1:0]   hdr_mt;
    logic [ARG_W-1:0]     ext_arg;
    logic [4:0]           ai;
    logic [MAJOR_W-1:0]   mt_in;
    logic                 over_str;
    logic                 over_arr;
    logic                 over_map;
    logic                 proc;

    cbst_stack #(.MAX_DEPTH(MAX_DEPTH)) u_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_stat  (st)
    );

    // a byte is processed when the result register can take its result
    assign proc   = i_in_valid && i_out_free;
    assign o_take = proc;

    assign ai      = i_data_byte[4:0];
    assign mt_in   = i_data_byte[7:5];
    assign ext_arg = {r_arg[ARG_W-BYTE_W-1:0], i_data_byte};

    // header completes on a short initial byte or on the last extension byte
    always_comb begin
        hdr_go  = 1'b0;
        hdr_arg = '0;
        hdr_mt  = '0;
        if (r_phase == PH_INIT && st.open <= OPEN_W'(MAX_DEPTH)
                && ai <= 5'(SHORT_ARG_MAX)) begin
            hdr_go  = 1'b1;
            hdr_arg = ARG_W'(ai);
            hdr_mt  = mt_in;
        end else if (r_phase == PH_EXT && r_ext_left == EXT_W'(1)) begin
            hdr_go  = 1'b1;
            hdr_arg = ext_arg;
            hdr_mt  = r_major;
        end
    end

    // limit checks on the completed header argument
    assign over_str = (|hdr_arg[ARG_W-1:STR_LIM_W]) || (hdr_arg[STR_LIM_W-1:0] > r_max_str);
    assign over_arr = (|hdr_arg[ARG_W-1:ARR_LIM_W]) || (hdr_arg[ARR_LIM_W-1:0] > r_max_arr);
    assign over_map = (|hdr_arg[ARG_W-1:MAP_LIM_W]) || (hdr_arg[MAP_LIM_W-1:0] > r_max_map);

    // per-byte step
    always_comb begin
        n_phase    = r_phase;
        n_major    = r_major;
        n_ext_left = r_ext_left;
        n_arg      = r_arg;
        n_pay_left = r_pay_left;
        cmd        = '0;
        res        = '0;
        res_vld    = 1'b0;

        case (r_phase)
            PH_INIT: begin
                if (st.open > OPEN_W'(MAX_DEPTH)) begin
                    res     = f_fault(ERR_TOO_DEEP);
                    res_vld = 1'b1;
                    n_phase = PH_IDLE;
                end else begin
                    n_major = mt_in;
                    if (ai > 5'(EXT_ARG_MAX)) begin
                        res     = f_fault(ERR_BAD_AI);
                        res_vld = 1'b1;
                        n_phase = PH_IDLE;
                    end else if (ai > 5'(SHORT_ARG_MAX)) begin
                        n_ext_left = EXT_W'(1) << ai[1:0];
                        n_arg      = '0;
                        n_phase    = PH_EXT;
                    end
                end
            end
            PH_EXT: begin
                n_arg      = ext_arg;
                n_ext_left = r_ext_left - EXT_W'(1);
            end
            PH_PAYLOAD: begin
                n_pay_left       = r_pay_left - STR_LIM_W'(1);
                res.kind         = KIND_PAYLOAD;
                res.major_type   = r_major;
                res.nesting      = st.open[NEST_W-1:0];
                res.payload_byte = i_data_byte;
                res_vld          = 1'b1;
                if (r_pay_left == STR_LIM_W'(1)) begin
                    cmd.op       = STK_POP;
                    res.top_done = st.close_all;
                    n_phase      = st.close_all ? PH_IDLE : PH_INIT;
                end
            end
            default: ;
        endcase

        // header complete: token or over-limit error
        if (hdr_go) begin
            res.kind       = KIND_HEADER;
            res.major_type = hdr_mt;
            res.argument   = hdr_arg;
            res.nesting    = st.open[NEST_W-1:0];
            res_vld        = 1'b1;
            n_phase        = PH_INIT;
            case (hdr_mt)
                MT_BSTR, MT_TSTR: begin
                    if (over_str) begin
                        res     = f_fault(ERR_OVER_LIM);
                        n_phase = PH_IDLE;
                    end else if (hdr_arg == '0) begin
                        cmd.op       = STK_POP;
                        res.top_done = st.close_all;
                        n_phase      = st.close_all ? PH_IDLE : PH_INIT;
                    end else begin
                        n_pay_left = hdr_arg[STR_LIM_W-1:0];
                        n_phase    = PH_PAYLOAD;
                    end
                end
                MT_ARRAY: begin
                    if (over_arr) begin
                        res     = f_fault(ERR_OVER_LIM);
                        n_phase = PH_IDLE;
                    end else if (hdr_arg == '0) begin
                        cmd.op       = STK_POP;
                        res.top_done = st.close_all;
                        n_phase      = st.close_all ? PH_IDLE : PH_INIT;
                    end else begin
                        cmd.op    = STK_PUSH;
                        cmd.count = hdr_arg[CNT_W-1:0];
                    end
                end
                MT_MAP: begin
                    if (over_map) begin
                        res     = f_fault(ERR_OVER_LIM);
                        n_phase = PH_IDLE;
                    end else if (hdr_arg == '0) begin
                        cmd.op       = STK_POP;
                        res.top_done = st.close_all;
                        n_phase      = st.close_all ? PH_IDLE : PH_INIT;
                    end else begin
                        // two children per pair
                        cmd.op    = STK_PUSH;
                        cmd.count = {hdr_arg[CNT_W-2:0], 1'b0};
                    end
                end
                MT_TAG: begin
                    cmd.op    = STK_PUSH;
                    cmd.count = CNT_W'(1);
                end
                default: begin
                    cmd.op       = STK_POP;
                    res.top_done = st.close_all;
                    n_phase      = st.close_all ? PH_IDLE : PH_INIT;
                end
            endcase
        end

        // end of buffer: truncation check, then parser restart
        if (i_end_of_buffer) begin
            if (n_phase != PH_IDLE) begin
                res     = f_fault(ERR_TRUNCATED);
                res_vld = 1'b1;
            end
            n_phase    = PH_INIT;
            n_major    = '0;
            n_ext_left = '0;
            n_arg      = '0;
            n_pay_left = '0;
            cmd        = '0;
            cmd.op     = STK_CLEAR;
        end

        // nothing moves without a transfer to process
        if (!proc) begin
            n_phase    = r_phase;
            n_major    = r_major;
            n_ext_left = r_ext_left;
            n_arg      = r_arg;
            n_pay_left = r_pay_left;
            cmd        = '0;
            res_vld    = 1'b0;
        end
    end

    assign o_res_valid = res_vld;
    assign o_res       = res;

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_INIT;
            r_major    <= '0;
            r_ext_left <= '0;
            r_pay_left <= '0;
        end else begin
            r_phase    <= n_phase;
            r_major    <= n_major;
            r_ext_left <= n_ext_left;
            r_pay_left <= n_pay_left;
        end
    end

    always_ff @(posedge i_clk) begin
        r_arg <= n_arg;
    end

    // limit registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_str <= STR_LIM_RST;
            r_max_arr <= ARR_LIM_RST;
            r_max_map <= MAP_LIM_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MAX_STRING: r_max_str <= i_cfg_data;
                CFG_MAX_ARRAY:  r_max_arr <= i_cfg_data[ARR_LIM_W-1:0];
                CFG_MAX_MAP:    r_max_map <= i_cfg_data[MAP_LIM_W-1:0];
                default: ;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc && i_end_of_buffer |=> r_phase == PH_INIT && st.open == '0)
    else $error("parser not restarted after end of buffer");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc && res_vld && res.top_done && !i_end_of_buffer
            |=> st.open == '0 && r_phase == PH_IDLE)
    else $error("top item reported done with containers still open");

endmodule

// ----- rtl/cbst_out_reg.sv -----
module cbst_out_reg
    import cbst_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_res,
    output logic    o_free,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_res
);

    logic    r_vld;
    t_result r_res;

    // free when empty or being emptied by a transfer this cycle
    assign o_free = !r_vld || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_load) begin
            r_vld <= 1'b1;
        end else if (i_ready) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_vld;
    assign o_res   = r_res;

endmodule

// ----- rtl/cbor_stream_tokenizer.sv -----
// channel   direction  handshake                     payload
// input     in         i_in_valid / o_in_ready       i_data_byte, i_end_of_buffer
// result    out        o_out_valid / i_out_ready     o_kind .. o_error_code
// config    in         i_cfg_we (no wait)            i_cfg_idx, i_cfg_data
//
// one byte per cycle sustained while the result register is free; a byte goes input register -> parse logic ->
// result register, so any result it gives is loaded into the result register from the input register's byte
// the parse step and the nesting stack update are computed together, including the close search
// over the stack levels
// synchronous active-low reset clears control state and loads the default limits
// a full result register stalls the parse step, and the input register then fills and
// drops o_in_ready
module cbor_stream_tokenizer
    import cbst_pkg::*;
#(
    parameter int MAX_DEPTH = MAX_DEPTH_DEF
)
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [BYTE_W-1:0]    i_data_byte,
    input  logic                 i_end_of_buffer,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [KIND_W-1:0]    o_kind,
    output logic [MAJOR_W-1:0]   o_major_type,
    output logic [ARG_W-1:0]     o_argument,
    output logic [NEST_W-1:0]    o_nesting,
    output logic [BYTE_W-1:0]    o_payload_byte,
    output logic                 o_top_done,
    output logic [ERR_W-1:0]     o_error_code
);

    logic              in_vld;
    logic [BYTE_W-1:0] in_byte;
    logic              in_eob;
    logic              take;
    logic              out_free;
    logic              res_vld;
    t_result           res;
    t_result           out_res;

    cbst_in_reg u_in_reg (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_in_valid),
        .o_ready         (o_in_ready),
        .i_data_byte     (i_data_byte),
        .i_end_of_buffer (i_end_of_buffer),
        .i_take          (take),
        .o_valid         (in_vld),
        .o_data_byte     (in_byte),
        .o_end_of_buffer (in_eob)
    );

    cbst_parser #(.MAX_DEPTH(MAX_DEPTH)) u_parser (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (in_vld),
        .i_data_byte     (in_byte),
        .i_end_of_buffer (in_eob),
        .i_out_free      (out_free),
        .o_take          (take),
        .o_res_valid     (res_vld),
        .o_res           (res)
    );

    cbst_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (res_vld),
        .i_res   (res),
        .o_free  (out_free),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_res   (out_res)
    );

    assign o_kind         = out_res.kind;
    assign o_major_type   = out_res.major_type;
    assign o_argument     = out_res.argument;
    assign o_nesting      = out_res.nesting;
    assign o_payload_byte = out_res.payload_byte;
    assign o_top_done     = out_res.top_done;
    assign o_error_code   = out_res.error_code;

endmodule

// ----- bench/cbor_stream_tokenizer_tb.sv -----
`timescale 1ns / 1ps

module cbor_stream_tokenizer_tb;
    import cbst_pkg::*;

    localparam int CYCLE_LIMIT   = 250000;
    localparam int ITEMS_PER_SET = 190;
    localparam int NUM_SETS      = 5;
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_CYCLES  = 6;

    // major types the package leaves unnamed
    localparam logic [MAJOR_W-1:0] MT_UINT   = 3'd0;
    localparam logic [MAJOR_W-1:0] MT_NINT   = 3'd1;
    localparam logic [MAJOR_W-1:0] MT_SIMPLE = 3'd7;

    localparam t_result NO_RES = '0;

    // mirror parse phases
    localparam logic [1:0] ST_HEAD = 2'd0;
    localparam logic [1:0] ST_EXT  = 2'd1;
    localparam logic [1:0] ST_PAY  = 2'd2;
    localparam logic [1:0] ST_IDLE = 2'd3;

    typedef struct {
        logic [BYTE_W-1:0] data;
        logic              eob;
        bit                typed;
        t_result           want;
    } t_dir_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_DAT_W-1:0] i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic [BYTE_W-1:0]    i_data_byte;
    logic                 i_end_of_buffer;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic [KIND_W-1:0]    o_kind;
    logic [MAJOR_W-1:0]   o_major_type;
    logic [ARG_W-1:0]     o_argument;
    logic [NEST_W-1:0]    o_nesting;
    logic [BYTE_W-1:0]    o_payload_byte;
    logic                 o_top_done;
    logic [ERR_W-1:0]     o_error_code;

    cbor_stream_tokenizer dut (.*);

    // tokenizer mirror state
    logic [CNT_W-1:0]     lvl_left [0:MAX_DEPTH_DEF];
    int unsigned          open_cnt;
    logic [1:0]           pst;
    logic [MAJOR_W-1:0]   hdr_mt;
    logic [EXT_W-1:0]     ext_left;
    logic [ARG_W-1:0]     arg_acc;
    logic [STR_LIM_W-1:0] pay_left;
    bit                   faulted;
    logic [STR_LIM_W-1:0] lim_str;
    logic [ARR_LIM_W-1:0] lim_arr;
    logic [MAP_LIM_W-1:0] lim_map;

    t_result           pending_tokens[$];
    logic [BYTE_W-1:0] buf_q[$];

    int  err_cnt;
    int  cyc;
    int  n_xfer;
    int  n_buf;
    int  n_hdr;
    int  n_pay;
    int  n_err;
    int  hold_left;
    bit  calm;

    // directed stimulus, default limits
    t_dir_row dir_rows [0:25] = '{
        '{8'h1B, 1'b0, 1'b0, NO_RES},
        '{8'hFF, 1'b0, 1'b0, NO_RES},
        '{8'hFF, 1'b0, 1'b0, NO_RES},
        '{8'hFF, 1'b0, 1'b0, NO_RES},
        '{8'hFF, 1'b0, 1'b0, NO_RES},
        '{8'hFF, 1'b0, 1'b0, NO_RES},
        '{8'hFF, 1'b0, 1'b0, NO_RES},
        '{8'hFF, 1'b0, 1'b0, NO_RES},
        '{8'hFF, 1'b1, 1'b1, '{KIND_HEADER, MT_UINT, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 8'd0,
                               1'b1, ERR_NONE}},
        '{8'hFC, 1'b0, 1'b1, '{KIND_ERROR, MT_UINT, 64'd0, 4'd0, 8'd0, 1'b0, ERR_BAD_AI}},
        '{8'h01, 1'b1, 1'b0, NO_RES},
        '{8'hC6, 1'b0, 1'b0, NO_RES},
        '{8'hA1, 1'b0, 1'b0, NO_RES},
        '{8'h62, 1'b0, 1'b0, NO_RES},
        '{8'h00, 1'b0, 1'b0, NO_RES},
        '{8'hFF, 1'b0, 1'b0, NO_RES},
        '{8'h38, 1'b0, 1'b0, NO_RES},
        '{8'hFF, 1'b1, 1'b0, NO_RES},
        '{8'h82, 1'b0, 1'b0, NO_RES},
        '{8'h41, 1'b0, 1'b0, NO_RES},
        '{8'h5A, 1'b1, 1'b1, '{KIND_ERROR, MT_UINT, 64'd0, 4'd0, 8'd0, 1'b0, ERR_TRUNCATED}},
        '{8'h99, 1'b0, 1'b0, NO_RES},
        '{8'h02, 1'b0, 1'b0, NO_RES},
        '{8'h01, 1'b1, 1'b1, '{KIND_ERROR, MT_UINT, 64'd0, 4'd0, 8'd0, 1'b0, ERR_OVER_LIM}},
        '{8'hF5, 1'b0, 1'b0, NO_RES},
        '{8'h55, 1'b1, 1'b0, NO_RES}
    };

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // cycle count and timeout
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc == CYCLE_LIMIT) begin
            $display("** cbor_stream_tokenizer: FAILED **");
            $finish;
        end
    end

    task automatic flag_error(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        err_cnt++;
    endtask

    task automatic cmp_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
        if (got !== want)
            flag_error($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
    endtask

    // parser mirror
    function automatic void clear_parse();
        foreach (lvl_left[i]) lvl_left[i] = '0;
        open_cnt = 0;
        pst      = ST_HEAD;
        hdr_mt   = '0;
        ext_left = '0;
        arg_acc  = '0;
        pay_left = '0;
        faulted  = 1'b0;
    endfunction

    function automatic t_result raise_fault(input logic [ERR_W-1:0] code);
        t_result r;
        r            = '0;
        r.kind       = KIND_ERROR;
        r.error_code = code;
        faulted      = 1'b1;
        pst          = ST_IDLE;
        return r;
    endfunction

    // count a finished item against its parents, closing exhausted containers
    function automatic bit close_item();
        bit busy;
        bit top;
        busy = 1'b1;
        top  = 1'b0;
        while (busy) begin
            if (open_cnt == 0 || open_cnt > MAX_DEPTH_DEF + 1) begin
                pst  = ST_IDLE;
                top  = 1'b1;
                busy = 1'b0;
            end else begin
                lvl_left[open_cnt-1] = lvl_left[open_cnt-1] - CNT_W'(1);
                if (lvl_left[open_cnt-1] != 0) begin
                    pst  = ST_HEAD;
                    busy = 1'b0;
                end else begin
                    open_cnt--;
                end
            end
        end
        return top;
    endfunction

    function automatic void push_lvl(input logic [ARG_W-1:0] count);
        if (open_cnt <= MAX_DEPTH_DEF) begin
            lvl_left[open_cnt] = count[CNT_W-1:0];
            open_cnt++;
        end
        pst = ST_HEAD;
    endfunction

    function automatic t_result finish_header();
        t_result          r;
        logic [ARG_W-1:0] a;
        logic [NEST_W-1:0] nest;
        bit               top;
        a    = arg_acc;
        nest = NEST_W'(open_cnt);
        top  = 1'b0;
        case (hdr_mt)
            MT_BSTR, MT_TSTR: begin
                if (a > lim_str) return raise_fault(ERR_OVER_LIM);
                if (a == 0) begin
                    top = close_item();
                end else begin
                    pay_left = a[STR_LIM_W-1:0];
                    pst      = ST_PAY;
                end
            end
            MT_ARRAY: begin
                if (a > lim_arr) return raise_fault(ERR_OVER_LIM);
                if (a == 0) top = close_item();
                else push_lvl(a);
            end
            MT_MAP: begin
                if (a > lim_map) return raise_fault(ERR_OVER_LIM);
                if (a == 0) top = close_item();
                else push_lvl(a << 1);
            end
            MT_TAG: push_lvl(ARG_W'(1));
            default: top = close_item();
        endcase
        r            = '0;
        r.kind       = KIND_HEADER;
        r.major_type = hdr_mt;
        r.argument   = a;
        r.nesting    = nest;
        r.top_done   = top;
        return r;
    endfunction

    // one accepted byte in, zero or one expected token out
    function automatic bit tokenize_byte(input logic [BYTE_W-1:0] b, input logic eob,
                                         output t_result r);
        bit                has;
        logic [4:0]        ai;
        logic [NEST_W-1:0] nest;
        bit                top;
        has = 1'b0;
        r   = '0;
        case (pst)
            ST_HEAD: begin
                if (open_cnt > MAX_DEPTH_DEF) begin
                    r   = raise_fault(ERR_TOO_DEEP);
                    has = 1'b1;
                end else begin
                    ai     = b[4:0];
                    hdr_mt = b[7:5];
                    if (ai <= SHORT_ARG_MAX) begin
                        arg_acc = ARG_W'(ai);
                        r       = finish_header();
                        has     = 1'b1;
                    end else if (ai <= EXT_ARG_MAX) begin
                        ext_left = EXT_W'(1 << (ai - SHORT_ARG_MAX - 1));
                        arg_acc  = '0;
                        pst      = ST_EXT;
                    end else begin
                        r   = raise_fault(ERR_BAD_AI);
                        has = 1'b1;
                    end
                end
            end
            ST_EXT: begin
                arg_acc  = {arg_acc[ARG_W-9:0], b};
                ext_left = ext_left - EXT_W'(1);
                if (ext_left == 0) begin
                    r   = finish_header();
                    has = 1'b1;
                end
            end
            ST_PAY: begin
                nest     = NEST_W'(open_cnt);
                pay_left = pay_left - STR_LIM_W'(1);
                top      = 1'b0;
                if (pay_left == 0) top = close_item();
                r.kind         = KIND_PAYLOAD;
                r.major_type   = hdr_mt;
                r.nesting      = nest;
                r.payload_byte = b;
                r.top_done     = top;
                has            = 1'b1;
            end
            default: ;
        endcase
        // end of buffer: truncation replaces whatever this byte gave
        if (eob) begin
            if (pst != ST_IDLE && !faulted) begin
                r   = raise_fault(ERR_TRUNCATED);
                has = 1'b1;
            end
            clear_parse();
        end
        return has;
    endfunction

    // append one byte to the buffer under construction
    function automatic void add_byte(input logic [BYTE_W-1:0] b);
        buf_q.insert(buf_q.size(), b);
    endfunction

    // random item generation
    function automatic logic [ARG_W-1:0] rand_arg();
        logic [ARG_W-1:0] a;
        if ($urandom_range(1) == 0) return ARG_W'($urandom_range(0, SHORT_ARG_MAX));
        a = {$urandom, $urandom};
        return a >> $urandom_range(0, ARG_W - 1);
    endfunction

    function automatic void put_head(input logic [MAJOR_W-1:0] mt, input logic [ARG_W-1:0] a);
        int lg;
        if (a <= SHORT_ARG_MAX && $urandom_range(3) != 0) begin
            add_byte({mt, a[4:0]});
            return;
        end
        lg = (a >> 8 == 0) ? 0 : (a >> 16 == 0) ? 1 : (a >> 32 == 0) ? 2 : 3;
        if ($urandom_range(5) == 0) lg = $urandom_range(lg, 3);
        add_byte({mt, 5'(SHORT_ARG_MAX + 1 + lg)});
        for (int i = (1 << lg) - 1; i >= 0; i--) add_byte(a[8*i +: 8]);
    endfunction

    // mostly small counts, sometimes right at or just past the limit
    function automatic int pick_count(input int lim, input int typ);
        int r;
        r = $urandom_range(99);
        if (r < 80) return $urandom_range(0, typ);
        if (r < 90) return lim + 1;
        return (lim <= 12) ? lim : $urandom_range(0, typ);
    endfunction

    function automatic void gen_item(input int depth);
        int               r;
        int               n;
        logic [MAJOR_W-1:0] mt;
        r = $urandom_range(99);
        if (r < 3) begin
            add_byte({3'($urandom_range(7)), 5'($urandom_range(EXT_ARG_MAX + 1, 31))});
            return;
        end
        if (depth >= 3) r = $urandom_range(3, 59);
        if (r < 25) begin
            mt = $urandom_range(1) ? MT_NINT : MT_UINT;
            put_head(mt, rand_arg());
        end else if (r < 45) begin
            mt = $urandom_range(1) ? MT_TSTR : MT_BSTR;
            n  = pick_count(int'(lim_str), 5);
            put_head(mt, ARG_W'(n));
            if (n <= int'(lim_str)) repeat (n) add_byte(BYTE_W'($urandom));
        end else if (r < 60) begin
            put_head(MT_SIMPLE, rand_arg());
        end else if (r < 75) begin
            n = pick_count(int'(lim_arr), 3);
            put_head(MT_ARRAY, ARG_W'(n));
            if (n <= int'(lim_arr)) repeat (n) gen_item(depth + 1);
        end else if (r < 90) begin
            n = pick_count(int'(lim_map), 2);
            put_head(MT_MAP, ARG_W'(n));
            if (n <= int'(lim_map)) repeat (2 * n) gen_item(depth + 1);
        end else begin
            put_head(MT_TAG, rand_arg());
            gen_item(depth + 1);
        end
    endfunction

    // add one expected result at the tail
    function automatic void queue_token(input t_result r);
        pending_tokens.insert(pending_tokens.size(), r);
    endfunction

    // one transfer on the input channel
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic eob, input bit typed,
                             input t_result want);
        t_result r;
        bit      has;
        if (!calm && $urandom_range(99) < 22) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_data_byte     <= b;
        i_end_of_buffer <= eob;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        has = tokenize_byte(b, eob, r);
        if (typed) queue_token(want);
        else if (has) queue_token(r);
        n_xfer++;
        @(negedge i_clk);
    endtask

    // one buffer: a generated item, noise, or a deep chain, maybe cut short or padded
    task automatic run_buffer(input bit deep, output int body);
        int r;
        int k;
        int last;
        buf_q.delete();
        r = $urandom_range(99);
        if (deep || r < 6) begin
            k = deep ? MAX_DEPTH_DEF + 1 : $urandom_range(MAX_DEPTH_DEF - 2, MAX_DEPTH_DEF + 2);
            repeat (k) add_byte($urandom_range(1) ? {MT_ARRAY, 5'd1} : {MT_TAG, 5'd1});
            gen_item(3);
        end else if (r < 14) begin
            repeat ($urandom_range(1, 8)) add_byte(BYTE_W'($urandom));
        end else begin
            gen_item(0);
        end
        body = buf_q.size();
        if ($urandom_range(99) < 15)
            repeat ($urandom_range(1, 3)) add_byte(BYTE_W'($urandom));
        last = buf_q.size() - 1;
        if ($urandom_range(99) < 10) last = $urandom_range(0, last);
        for (int i = 0; i <= last; i++) send_byte(buf_q[i], i == last, 1'b0, NO_RES);
        n_buf++;
    endtask

    // drop valid, let every expected token arrive, then let the pipeline empty
    task automatic settle();
        i_in_valid <= 1'b0;
        for (int w = 0; w < 4000 && pending_tokens.size() != 0; w++) @(posedge i_clk);
        if (pending_tokens.size() != 0) begin
            flag_error($sformatf("%0d expected results never arrived", pending_tokens.size()));
            pending_tokens.delete();
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_limits(input logic [CFG_DAT_W-1:0] s, input logic [CFG_DAT_W-1:0] a,
                                input logic [CFG_DAT_W-1:0] m);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_MAX_STRING;
        i_cfg_data <= s;
        @(negedge i_clk);
        i_cfg_idx  <= CFG_MAX_ARRAY;
        i_cfg_data <= a;
        @(negedge i_clk);
        i_cfg_idx  <= CFG_MAX_MAP;
        i_cfg_data <= m;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        lim_str = s[STR_LIM_W-1:0];
        lim_arr = a[ARR_LIM_W-1:0];
        lim_map = m[MAP_LIM_W-1:0];
    endtask

    // result receiver: random stalls, a long hold-off on request
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_out_ready <= 1'b0;
                hold_left--;
            end else if (calm) begin
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= ($urandom_range(99) >= 18);
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = '{o_kind, o_major_type, o_argument, o_nesting, o_payload_byte, o_top_done,
                    o_error_code};
            case (got.kind)
                KIND_HEADER:  n_hdr++;
                KIND_PAYLOAD: n_pay++;
                default:      n_err++;
            endcase
            if (pending_tokens.size() == 0) begin
                flag_error($sformatf("result transfer with nothing pending, kind %0d",
                                     got.kind));
            end else begin
                want = pending_tokens.pop_front();
                cmp_field("kind", 64'(got.kind), 64'(want.kind));
                cmp_field("major_type", 64'(got.major_type), 64'(want.major_type));
                cmp_field("argument", got.argument, want.argument);
                cmp_field("nesting", 64'(got.nesting), 64'(want.nesting));
                cmp_field("payload_byte", 64'(got.payload_byte), 64'(want.payload_byte));
                cmp_field("top_done", 64'(got.top_done), 64'(want.top_done));
                cmp_field("error_code", 64'(got.error_code), 64'(want.error_code));
            end
        end
    end

    // main sequence
    initial begin
        int sent;
        int body;
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = CFG_MAX_STRING;
        i_cfg_data      = '0;
        i_in_valid      = 1'b0;
        i_data_byte     = '0;
        i_end_of_buffer = 1'b0;
        err_cnt   = 0;
        cyc       = 0;
        n_xfer    = 0;
        n_buf     = 0;
        n_hdr     = 0;
        n_pay     = 0;
        n_err     = 0;
        hold_left = 0;
        calm      = 1'b0;
        lim_str   = STR_LIM_RST;
        lim_arr   = ARR_LIM_RST;
        lim_map   = MAP_LIM_RST;
        clear_parse();
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[k])
            send_byte(dir_rows[k].data, dir_rows[k].eob, dir_rows[k].typed, dir_rows[k].want);

        // random buffers under several limit settings
        for (int set_i = 0; set_i < NUM_SETS; set_i++) begin
            settle();
            case (set_i)
                1: write_limits('0, '0, '0);
                2: write_limits(STR_LIM_RST, CFG_DAT_W'(ARR_LIM_RST), CFG_DAT_W'(MAP_LIM_RST));
                3, 4: write_limits(CFG_DAT_W'($urandom_range(0, 8)),
                                   CFG_DAT_W'($urandom_range(0, 4)),
                                   CFG_DAT_W'($urandom_range(0, 3)));
                default: ;
            endcase
            calm = (set_i == 3);
            if (set_i == 2) hold_left = HOLD_CYCLES;
            sent = 0;
            while (sent < ITEMS_PER_SET) begin
                run_buffer(set_i == 0 && sent == 0, body);
                sent += body;
            end
        end
        settle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("ran %0d buffers, %0d byte transfers, %0d limit settings",
                 n_buf, n_xfer, NUM_SETS);
        $display("results checked: %0d header tokens, %0d payload bytes, %0d errors",
                 n_hdr, n_pay, n_err);
        if (err_cnt == 0) begin
            $display("** cbor_stream_tokenizer: PASSED **");
        end else begin
            $display("** cbor_stream_tokenizer: FAILED **");
        end
        $finish;
    end

endmodule

// ----- cbor_stream_tokenizer.f -----
rtl/cbst_pkg.sv
rtl/cbst_in_reg.sv
rtl/cbst_stack.sv
rtl/cbst_parser.sv
rtl/cbst_out_reg.sv
rtl/cbor_stream_tokenizer.sv
bench/cbor_stream_tokenizer_tb.sv
